// ===== sv/rshe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rshe_pkg
// Shared constants, coefficient tables and control types for the real
// spherical harmonic evaluator.
// ----------------------------------------------------------------------------
package rshe_pkg;

	localparam int L_MAX       = 7;
	localparam int ANGLE_BITS  = 16;
	localparam int FRAC_BITS   = 20;

	localparam int ANGLE_W     = 16;
	localparam int DEG_W       = 4;
	localparam int ORD_W       = 5;
	localparam int VAL_W       = 24;

	localparam int IQ          = 28;
	localparam int WORD_W      = 34;
	localparam int MAG_W       = WORD_W - 1;
	localparam int CORDIC_W    = 32;
	localparam int CZ_W        = 33;
	localparam int CORDIC_STEPS = 28;
	localparam int STEP_W      = 5;
	localparam int IDX_W       = 3;
	localparam int AM_W        = 5;
	localparam int RND_SH      = IQ - FRAC_BITS;

	localparam logic signed [CORDIC_W-1:0] CORDIC_START = 32'sd163008219;
	localparam logic signed [WORD_W-1:0]   INV_SQRT_4PI = 34'sd75724244;
	localparam logic signed [WORD_W-1:0]   SQRT2_Q      = 34'sd379625062;
	localparam logic [VAL_W-1:0]           OUT_MAX      = 24'h7FFFFF;
	localparam logic [VAL_W:0]             OUT_MIN_MAG  = 25'h0800000;

	typedef logic [63:0][WORD_W-1:0] coef_tab_t;
	typedef logic [7:0][WORD_W-1:0]  coef_row_t;

	// arctangent of 2^-i in turn units (2^32 per turn)
	function automatic logic [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [CORDIC_W-1:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			default: v = '0;
		endcase
		return v;
	endfunction

	// sqrt(num/den) in Q28, elaboration only: shift-subtract quotient then
	// bitwise integer square root
	function automatic logic [WORD_W-1:0] sq_ratio(input int unsigned num,
		input int unsigned den);
		longint unsigned dvd;
		longint unsigned q;
		longint unsigned rem;
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		if (den == 0) begin
			return '0;
		end
		dvd = longint'(num & 1023) << 54;
		q   = 0;
		rem = 0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 1) | ((dvd >> i) & 64'd1);
			if (rem >= longint'(den)) begin
				rem = rem - longint'(den);
				q   = q | (64'd1 << i);
			end
		end
		v = q;
		r = 0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return WORD_W'(r << 1);
	endfunction

	function automatic coef_row_t build_ak();
		coef_row_t t;
		for (int k = 0; k < 8; k++) begin
			t[k] = (k == 0) ? '0 : sq_ratio(2 * k + 1, 2 * k);
		end
		return t;
	endfunction

	function automatic coef_row_t build_c();
		coef_row_t t;
		for (int m = 0; m < 8; m++) begin
			t[m] = sq_ratio(2 * m + 3, 1);
		end
		return t;
	endfunction

	function automatic coef_tab_t build_a();
		coef_tab_t t;
		for (int n = 0; n < 8; n++) begin
			for (int m = 0; m < 8; m++) begin
				t[n * 8 + m] = (n >= m + 2) ?
					sq_ratio(4 * n * n - 1, n * n - m * m) : '0;
			end
		end
		return t;
	endfunction

	function automatic coef_tab_t build_b();
		coef_tab_t t;
		for (int n = 0; n < 8; n++) begin
			for (int m = 0; m < 8; m++) begin
				t[n * 8 + m] = (n >= m + 2) ?
					sq_ratio((n - 1) * (n - 1) - m * m, 4 * (n - 1) * (n - 1) - 1) : '0;
			end
		end
		return t;
	endfunction

	localparam coef_row_t AK_TAB = build_ak();
	localparam coef_row_t C_TAB  = build_c();
	localparam coef_tab_t A_TAB  = build_a();
	localparam coef_tab_t B_TAB  = build_b();

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,
		OP_AK_S,
		OP_T_P_NEG,
		OP_C_X,
		OP_T_P1,
		OP_X_P1,
		OP_B_P,
		OP_A_D,
		OP_MOVE,
		OP_SQ2_P,
		OP_T_CS,
		OP_FINISH
	} mul_op_t;

	typedef enum logic [2:0] {
		CR_NONE,
		CR_LOAD_POLAR,
		CR_LOAD_AZ,
		CR_STEP,
		CR_LATCH_POLAR,
		CR_LATCH_AZ
	} cordic_op_t;

	typedef struct packed {
		logic              capture;
		mul_op_t           op;
		cordic_op_t        cordic;
		logic [IDX_W-1:0]  idx;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic [AM_W-1:0]  am;
		logic [DEG_W-1:0] l;
		logic             invalid;
		logic             m_zero;
	} dp_status_t;

endpackage

// ===== sv/rshe_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rshe_req_if
// Request channel: angles, degree and order with valid/ready.
// ----------------------------------------------------------------------------
interface rshe_req_if;
	logic                                valid;
	logic                                ready;
	logic [rshe_pkg::ANGLE_W-1:0]        polar_angle;
	logic [rshe_pkg::ANGLE_W-1:0]        azimuth_angle;
	logic [rshe_pkg::DEG_W-1:0]          degree;
	logic signed [rshe_pkg::ORD_W-1:0]   order;

	modport source (output valid, polar_angle, azimuth_angle, degree, order, input ready);
	modport sink   (input valid, polar_angle, azimuth_angle, degree, order, output ready);
endinterface

// ===== sv/rshe_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rshe_rsp_if
// Response channel: harmonic value and error flag with valid/ready.
// ----------------------------------------------------------------------------
interface rshe_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [rshe_pkg::VAL_W-1:0] harmonic_value;
	logic                              invalid_request;

	modport source (output valid, harmonic_value, invalid_request, input ready);
	modport sink   (input valid, harmonic_value, invalid_request, output ready);
endinterface

// ===== sv/rshe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rshe_dp
// Datapath: request registers, iterative CORDIC, one shared Q28 multiplier
// with its working registers, output rounding and result register.
// ----------------------------------------------------------------------------
module rshe_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rshe_pkg::dp_cmd_t                 cmd,
	input  logic [rshe_pkg::ANGLE_W-1:0]      polar_angle,
	input  logic [rshe_pkg::ANGLE_W-1:0]      azimuth_angle,
	input  logic [rshe_pkg::DEG_W-1:0]        degree,
	input  logic signed [rshe_pkg::ORD_W-1:0] order,
	output rshe_pkg::dp_status_t              status,
	output logic signed [rshe_pkg::VAL_W-1:0] harmonic_value,
	output logic                              invalid_request
);
	localparam int W  = rshe_pkg::WORD_W;
	localparam int MW = rshe_pkg::MAG_W;
	localparam int CW = rshe_pkg::CORDIC_W;
	localparam int ZW = rshe_pkg::CZ_W;

	logic [rshe_pkg::ANGLE_W-1:0]        theta_q, phi_q;
	logic [rshe_pkg::DEG_W-1:0]          l_q;
	logic signed [rshe_pkg::ORD_W-1:0]   m_q;
	logic signed [CW-1:0]                cx_q, cy_q;
	logic signed [ZW-1:0]                cz_q;
	logic [1:0]                          quad_q;
	logic signed [W-1:0]                 x_q, s_q, p_q, p1_q, t_q, u_q, cs_q;
	logic signed [rshe_pkg::VAL_W-1:0]   val_q;
	logic                                inv_q;

	logic [rshe_pkg::AM_W-1:0]           am;
	logic [2:0]                          am3;
	logic [5:0]                          tab_idx;
	logic [CW-1:0]                       theta32, phi32, az32, load_ang;
	logic signed [CW-1:0]                dx, dy, cos_v, sin_v;
	logic signed [W-1:0]                 ma_s, mb_s, prod;
	logic [MW-1:0]                       ma, mb;
	logic [2*MW-1:0]                     pr, pr_rnd;
	logic [W-1:0]                        pr_mag;
	logic signed [W-1:0]                 y_sel;
	logic [W-1:0]                        y_mag, y_rnd;
	logic signed [rshe_pkg::VAL_W-1:0]   y_out;

	assign am  = m_q[rshe_pkg::ORD_W-1] ? rshe_pkg::AM_W'(-m_q) : rshe_pkg::AM_W'(m_q);
	assign am3 = am[2:0];
	assign tab_idx = {cmd.idx, am3};

	assign status.am      = am;
	assign status.l       = l_q;
	assign status.invalid = (l_q > rshe_pkg::DEG_W'(rshe_pkg::L_MAX)) ||
		(am > rshe_pkg::AM_W'(l_q));
	assign status.m_zero  = (m_q == '0);

	// angles scaled to a 32-bit turn
	assign theta32 = CW'(theta_q) << (CW - rshe_pkg::ANGLE_BITS);
	assign phi32   = CW'(phi_q) << (CW - rshe_pkg::ANGLE_BITS);
	assign az32    = CW'(phi32 * am3);
	assign load_ang = (cmd.cordic == rshe_pkg::CR_LOAD_AZ) ? az32 : theta32;

	assign dx = cy_q >>> cmd.step;
	assign dy = cx_q >>> cmd.step;

	always_comb begin
		case (quad_q)
			2'd0:    begin cos_v = cx_q;  sin_v = cy_q;  end
			2'd1:    begin cos_v = -cy_q; sin_v = cx_q;  end
			2'd2:    begin cos_v = -cx_q; sin_v = -cy_q; end
			default: begin cos_v = cy_q;  sin_v = -cx_q; end
		endcase
	end

	// operand selection for the shared multiplier
	always_comb begin
		ma_s = t_q;
		mb_s = p_q;
		case (cmd.op)
			rshe_pkg::OP_AK_S:  begin ma_s = rshe_pkg::AK_TAB[cmd.idx]; mb_s = s_q; end
			rshe_pkg::OP_C_X:   begin ma_s = rshe_pkg::C_TAB[am3];     mb_s = x_q; end
			rshe_pkg::OP_X_P1:  begin ma_s = x_q;                      mb_s = p1_q; end
			rshe_pkg::OP_B_P:   begin ma_s = rshe_pkg::B_TAB[tab_idx]; mb_s = p_q; end
			rshe_pkg::OP_A_D:   begin ma_s = rshe_pkg::A_TAB[tab_idx]; mb_s = t_q - u_q; end
			rshe_pkg::OP_SQ2_P: begin ma_s = rshe_pkg::SQRT2_Q;        mb_s = p_q; end
			rshe_pkg::OP_T_CS:  begin ma_s = t_q;                      mb_s = cs_q; end
			default:            begin ma_s = t_q;                      mb_s = p_q; end
		endcase
	end

	// magnitude product, rounded half away from zero to Q28
	assign ma     = ma_s[W-1] ? MW'(-ma_s) : MW'(ma_s);
	assign mb     = mb_s[W-1] ? MW'(-mb_s) : MW'(mb_s);
	assign pr     = ma * mb;
	assign pr_rnd = pr + ((2*MW)'(1) << (rshe_pkg::IQ - 1));
	assign pr_mag = W'(pr_rnd >> rshe_pkg::IQ);
	assign prod   = (ma_s[W-1] != mb_s[W-1]) ? -signed'(pr_mag) : signed'(pr_mag);

	// output rounding and saturation
	assign y_sel = status.m_zero ? p_q : t_q;
	assign y_mag = y_sel[W-1] ? W'(-y_sel) : W'(y_sel);
	assign y_rnd = (y_mag + (W'(1) << (rshe_pkg::RND_SH - 1))) >> rshe_pkg::RND_SH;
	always_comb begin
		if (y_sel[W-1]) begin
			y_out = (y_rnd > W'(rshe_pkg::OUT_MIN_MAG)) ?
				rshe_pkg::VAL_W'(-signed'(W'(rshe_pkg::OUT_MIN_MAG))) :
				rshe_pkg::VAL_W'(-signed'(y_rnd));
		end else begin
			y_out = (y_rnd > W'(rshe_pkg::OUT_MAX)) ?
				signed'(rshe_pkg::OUT_MAX) : rshe_pkg::VAL_W'(y_rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			theta_q <= polar_angle;
			phi_q   <= azimuth_angle;
			l_q     <= degree;
			m_q     <= order;
		end

		case (cmd.cordic)
			rshe_pkg::CR_LOAD_POLAR, rshe_pkg::CR_LOAD_AZ: begin
				cx_q   <= rshe_pkg::CORDIC_START;
				cy_q   <= '0;
				cz_q   <= ZW'(load_ang[29:0]);
				quad_q <= load_ang[31:30];
			end
			rshe_pkg::CR_STEP: begin
				if (!cz_q[ZW-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - signed'(ZW'(rshe_pkg::atan_turn(cmd.step)));
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + signed'(ZW'(rshe_pkg::atan_turn(cmd.step)));
				end
			end
			rshe_pkg::CR_LATCH_POLAR: begin
				x_q <= W'(cos_v);
				s_q <= sin_v[CW-1] ? -W'(sin_v) : W'(sin_v);
			end
			rshe_pkg::CR_LATCH_AZ: begin
				cs_q <= m_q[rshe_pkg::ORD_W-1] ? W'(sin_v) : W'(cos_v);
			end
			default: ;
		endcase

		case (cmd.op)
			rshe_pkg::OP_INIT:    p_q  <= rshe_pkg::INV_SQRT_4PI;
			rshe_pkg::OP_AK_S:    t_q  <= prod;
			rshe_pkg::OP_T_P_NEG: p_q  <= -prod;
			rshe_pkg::OP_C_X:     t_q  <= prod;
			rshe_pkg::OP_T_P1:    p1_q <= prod;
			rshe_pkg::OP_X_P1:    t_q  <= prod;
			rshe_pkg::OP_B_P:     u_q  <= prod;
			rshe_pkg::OP_A_D: begin
				p_q  <= p1_q;
				p1_q <= prod;
			end
			rshe_pkg::OP_MOVE:    p_q  <= p1_q;
			rshe_pkg::OP_SQ2_P:   t_q  <= prod;
			rshe_pkg::OP_T_CS:    t_q  <= prod;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
			val_q <= '0;
		end else if (cmd.op == rshe_pkg::OP_FINISH) begin
			inv_q <= status.invalid;
			val_q <= status.invalid ? '0 : y_out;
		end
	end

	assign harmonic_value  = val_q;
	assign invalid_request = inv_q;
endmodule

// ===== sv/rshe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rshe_ctrl
// Sequencer: walks CORDIC, Legendre recurrence and azimuth scaling, and
// owns both handshakes.
// ----------------------------------------------------------------------------
module rshe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  rshe_pkg::dp_status_t status,
	output rshe_pkg::dp_cmd_t    cmd
);
	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_TRIG1, S_LATCH1, S_PMM_A, S_PMM_B, S_P1_A, S_P1_B,
		S_REC_X, S_REC_B, S_REC_A, S_MOVE, S_AZ_LOAD, S_TRIG2, S_LATCH2,
		S_SQ2, S_YMUL, S_FINISH
	} state_t;

	localparam int IW = rshe_pkg::IDX_W;

	state_t                        state_q, after_pmm;
	logic [rshe_pkg::STEP_W-1:0]   cnt_q;
	logic [IW-1:0]                 k_q, n_q;
	logic                          rsp_valid_q;
	logic                          rsp_free;
	logic [rshe_pkg::DEG_W-1:0]    n_first;
	logic                          last_step;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign n_first   = rshe_pkg::DEG_W'(status.am) + rshe_pkg::DEG_W'(2);
	assign last_step = (cnt_q == rshe_pkg::STEP_W'(rshe_pkg::CORDIC_STEPS - 1));

	always_comb begin
		if (status.l > rshe_pkg::DEG_W'(status.am)) begin
			after_pmm = S_P1_A;
		end else if (status.m_zero) begin
			after_pmm = S_FINISH;
		end else begin
			after_pmm = S_AZ_LOAD;
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.op      = rshe_pkg::OP_NONE;
		cmd.cordic  = rshe_pkg::CR_NONE;
		cmd.step    = cnt_q;
		cmd.idx     = n_q;
		req_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			S_CHECK:   cmd.cordic = rshe_pkg::CR_LOAD_POLAR;
			S_TRIG1:   cmd.cordic = rshe_pkg::CR_STEP;
			S_LATCH1: begin
				cmd.cordic = rshe_pkg::CR_LATCH_POLAR;
				cmd.op     = rshe_pkg::OP_INIT;
			end
			S_PMM_A: begin
				cmd.op  = rshe_pkg::OP_AK_S;
				cmd.idx = k_q;
			end
			S_PMM_B:   cmd.op = rshe_pkg::OP_T_P_NEG;
			S_P1_A:    cmd.op = rshe_pkg::OP_C_X;
			S_P1_B:    cmd.op = rshe_pkg::OP_T_P1;
			S_REC_X:   cmd.op = rshe_pkg::OP_X_P1;
			S_REC_B:   cmd.op = rshe_pkg::OP_B_P;
			S_REC_A:   cmd.op = rshe_pkg::OP_A_D;
			S_MOVE:    cmd.op = rshe_pkg::OP_MOVE;
			S_AZ_LOAD: cmd.cordic = rshe_pkg::CR_LOAD_AZ;
			S_TRIG2:   cmd.cordic = rshe_pkg::CR_STEP;
			S_LATCH2:  cmd.cordic = rshe_pkg::CR_LATCH_AZ;
			S_SQ2:     cmd.op = rshe_pkg::OP_SQ2_P;
			S_YMUL:    cmd.op = rshe_pkg::OP_T_CS;
			S_FINISH:  cmd.op = rsp_free ? rshe_pkg::OP_FINISH : rshe_pkg::OP_NONE;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			n_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// in S_FINISH the beat is replaced rather than dropped
			if (rsp_valid_q && rsp_ready && (state_q != S_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					cnt_q   <= '0;
					state_q <= status.invalid ? S_FINISH : S_TRIG1;
				end
				S_TRIG1: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= S_LATCH1;
					end
				end
				S_LATCH1: begin
					k_q     <= IW'(1);
					state_q <= (status.am != '0) ? S_PMM_A : after_pmm;
				end
				S_PMM_A: state_q <= S_PMM_B;
				S_PMM_B: begin
					if (k_q == status.am[IW-1:0]) begin
						state_q <= after_pmm;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_PMM_A;
					end
				end
				S_P1_A: state_q <= S_P1_B;
				S_P1_B: begin
					n_q     <= n_first[IW-1:0];
					state_q <= (n_first > status.l) ? S_MOVE : S_REC_X;
				end
				S_REC_X: state_q <= S_REC_B;
				S_REC_B: state_q <= S_REC_A;
				S_REC_A: begin
					if (rshe_pkg::DEG_W'(n_q) == status.l) begin
						state_q <= S_MOVE;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_REC_X;
					end
				end
				S_MOVE: state_q <= status.m_zero ? S_FINISH : S_AZ_LOAD;
				S_AZ_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_TRIG2;
				end
				S_TRIG2: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= S_LATCH2;
					end
				end
				S_LATCH2: state_q <= S_SQ2;
				S_SQ2:    state_q <= S_YMUL;
				S_YMUL:   state_q <= S_FINISH;
				S_FINISH: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
endmodule

// ===== sv/real_spherical_harmonic_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// real_spherical_harmonic_eval
// Real orthonormal spherical harmonic Y_lm (Condon-Shortley phase), Q3.20.
// ----------------------------------------------------------------------------
// One request at a time. A request with degree above 7 or |order| above
// degree is answered with invalid_request set and a zero value, without
// any CORDIC steps or recurrence. A valid request runs the polar CORDIC,
// the P_mm loop over |m|, the recurrence up to l when l > |m|, then the
// azimuth CORDIC and scaling when m is nonzero, and finally loads the
// result. The run time is set by the single 28-step rotation CORDIC, used
// once or twice per valid request, and by the one shared 33x33 multiplier
// that every recurrence product passes through.
// The result sits in an output register, so the next request is taken as
// soon as the sequencer returns to idle, even while a response waits.
// ----------------------------------------------------------------------------
module real_spherical_harmonic_eval (
	input  logic       clk,
	input  logic       arst_n,
	rshe_req_if.sink   req,
	rshe_rsp_if.source rsp
);
	rshe_pkg::dp_cmd_t    cmd;
	rshe_pkg::dp_status_t status;

	// sequencer: handshakes, loop counters, command decode
	rshe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: CORDIC, shared multiplier, rounding, result register
	rshe_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.polar_angle     (req.polar_angle),
		.azimuth_angle   (req.azimuth_angle),
		.degree          (req.degree),
		.order           (req.order),
		.status          (status),
		.harmonic_value  (rsp.harmonic_value),
		.invalid_request (rsp.invalid_request)
	);
endmodule

// ===== tb/sv/tb_real_spherical_harmonic_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_real_spherical_harmonic_eval
// Self-checking bench for the spherical harmonic evaluator: directed corner
// requests, then random requests under several idle/stall mixes. Each
// response is compared field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_real_spherical_harmonic_eval;

	localparam int CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;

	rshe_req_if req ();
	rshe_rsp_if rsp ();

	real_spherical_harmonic_eval uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// one predicted response
	typedef struct {
		logic signed [rshe_pkg::VAL_W-1:0] value;
		logic                              bad;
	} harmonic_t;

	harmonic_t harmonic_q[$];
	int        mismatches;
	int        cycles;
	int        send_idle_pct;
	int        recv_stall_pct;

	// ------------------------------------------------------------------
	// Clock, reset, cycle guard
	// ------------------------------------------------------------------
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor: fixed point, 28 fraction bits throughout
	// ------------------------------------------------------------------
	localparam longint Q_ONE_HALF = 64'sd1 << (rshe_pkg::IQ - 1);

	// arctangent of 2^-i in turn units, 2^32 per turn
	function automatic longint arc_step(int i);
		longint t[28] = '{
			64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
			64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
			64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
			64'h00000014, 64'h0000000A, 64'h00000005};
		return t[i];
	endfunction

	// product on magnitudes, rounded half away from zero
	function automatic longint qmul(longint a, longint b);
		logic            neg;
		longint unsigned pr;
		longint unsigned r;
		neg = (a < 0) != (b < 0);
		pr  = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
		r   = (pr + Q_ONE_HALF) >> rshe_pkg::IQ;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint root_ratio(longint unsigned num, longint unsigned den);
		if (den == 0)
			return 0;
		num &= 1023;
		return longint'(int_sqrt((num << 54) / den) << 1);
	endfunction

	// cos/sin of a 32-bit turn angle by rotation CORDIC; >>> floors
	task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		x = 163008219;
		y = 0;
		z = longint'(ang[29:0]);
		for (int i = 0; i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step(i);
			end else begin
				x += dx; y -= dy; z += arc_step(i);
			end
		end
		case (ang[31:30])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic predict_harmonic(input logic [15:0] th, input logic [15:0] ph,
		input logic [3:0] l, input logic signed [4:0] m, output harmonic_t h);
		int              am;
		longint          x;
		longint          s;
		longint          p;
		longint          p1;
		longint          pn;
		longint          a;
		longint          b;
		longint          y;
		longint          cp;
		longint          sp;
		longint unsigned r;
		logic [31:0]     az;
		am = (m < 0) ? -int'(m) : int'(m);
		h.bad   = 1'b0;
		h.value = '0;
		if (l > rshe_pkg::L_MAX || am > l) begin
			h.bad = 1'b1;
			return;
		end
		rotate({th, 16'h0}, x, s);
		if (s < 0)
			s = -s;
		p = 75724244;
		for (int k = 1; k <= am; k++)
			p = -qmul(qmul(root_ratio(2 * k + 1, 2 * k), s), p);
		if (l > am) begin
			p1 = qmul(qmul(root_ratio(2 * am + 3, 1), x), p);
			for (int n = am + 2; n <= l; n++) begin
				a  = root_ratio(4 * n * n - 1, n * n - am * am);
				b  = root_ratio((n - 1) * (n - 1) - am * am, 4 * (n - 1) * (n - 1) - 1);
				pn = qmul(a, qmul(x, p1) - qmul(b, p));
				p  = p1;
				p1 = pn;
			end
			p = p1;
		end
		if (m == 0) begin
			y = p;
		end else begin
			az = 32'(am) * {ph, 16'h0};
			rotate(az, cp, sp);
			y = qmul(qmul(379625062, p), (m > 0) ? cp : sp);
		end
		r = longint'(y < 0 ? -y : y);
		r = (r + (64'd1 << (rshe_pkg::RND_SH - 1))) >> rshe_pkg::RND_SH;
		if (y < 0)
			h.value = (r > 8388608) ? 24'sh800000 : rshe_pkg::VAL_W'(-longint'(r));
		else
			h.value = (r > 8388607) ? 24'sh7FFFFF : rshe_pkg::VAL_W'(r);
	endtask

	// ------------------------------------------------------------------
	// Driving and checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
	endtask

	// one request beat; random idle before it, held until accepted.
	// valid stays high after the beat; idle cycles or the end of the run
	// drop it
	task automatic send_request(input logic [15:0] th, input logic [15:0] ph,
		input logic [3:0] l, input logic signed [4:0] m);
		harmonic_t h;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		predict_harmonic(th, ph, l, m, h);
		req.valid         <= 1'b1;
		req.polar_angle   <= th;
		req.azimuth_angle <= ph;
		req.degree        <= l;
		req.order         <= m;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		harmonic_q.push_back(h);
		@(negedge clk);
	endtask

	// receiver stall
	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		harmonic_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (harmonic_q.size() == 0) begin
				report_mismatch("unexpected beat", rsp.harmonic_value, 0);
			end else begin
				w = harmonic_q.pop_front();
				if (rsp.harmonic_value !== w.value)
					report_mismatch("harmonic_value", rsp.harmonic_value, w.value);
				if (rsp.invalid_request !== w.bad)
					report_mismatch("invalid_request", rsp.invalid_request, w.bad);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic send_random_valid();
		logic [3:0] l;
		int         m;
		l = 4'($urandom_range(rshe_pkg::L_MAX));
		m = $urandom_range(2 * l) - l;
		send_request(16'($urandom), 16'($urandom), l, 5'(m));
	endtask

	// corners: angle extremes, each pole, highest orders, bad requests
	task automatic test_directed();
		send_request(16'h0000, 16'h0000, 4'd0, 5'sd0);
		send_request(16'h8000, 16'hFFFF, 4'd7, 5'sd7);
		send_request(16'h8000, 16'h0000, 4'd7, -5'sd7);
		send_request(16'h0000, 16'h4000, 4'd7, 5'sd0);
		send_request(16'h4000, 16'h4000, 4'd7, 5'sd0);
		send_request(16'h4000, 16'h2000, 4'd7, 5'sd7);
		send_request(16'h4000, 16'h2000, 4'd7, -5'sd7);
		send_request(16'h2AAA, 16'hC000, 4'd5, 5'sd3);
		send_request(16'hFFFF, 16'hFFFF, 4'd6, -5'sd1);  // theta past pi
		send_request(16'hC000, 16'h8000, 4'd3, 5'sd2);
		send_request(16'h1234, 16'h5678, 4'd1, -5'sd1);
		send_request(16'h1000, 16'h0001, 4'd2, 5'sd1);
		send_request(16'h0000, 16'h0000, 4'd8, 5'sd0);  // degree too high
		send_request(16'hFFFF, 16'hFFFF, 4'd15, -5'sd15);
		send_request(16'h4000, 16'h4000, 4'd15, -5'sd16);
		send_request(16'h4000, 16'h4000, 4'd3, 5'sd4);  // order above degree
		send_request(16'h4000, 16'h4000, 4'd0, -5'sd1);
		send_request(16'h4000, 16'h4000, 4'd7, 5'sd15);
	endtask

	// mostly well-formed requests, some out of range
	task automatic test_random(input int count, input int idle, input int stall);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		repeat (count) begin
			if ($urandom_range(9) == 0)
				send_request(16'($urandom), 16'($urandom), 4'($urandom), 5'($urandom));
			else
				send_random_valid();
		end
	endtask

	initial begin
		cycles         = 0;
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n            = 1'b0;
		req.valid         = 1'b0;
		req.polar_angle   = '0;
		req.azimuth_angle = '0;
		req.degree        = '0;
		req.order         = '0;
		rsp.ready         = 1'b1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(400, 0, 0);
		test_random(400, 49, 0);
		test_random(400, 0, 49);
		test_random(430, 22, 22);
		req.valid <= 1'b0;
		while (harmonic_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
